// ----- rtl/ps2s1_pkg.sv -----
package ps2s1_pkg;

    localparam int KEY_TABLE_LENGTH = 128;
    localparam int KEY_TEXT_LEN     = 84;

    localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
    localparam logic [6:0] SC_ENTER      = 7'h1C;
    localparam logic [6:0] SC_BACKSPACE  = 7'h0E;
    localparam logic [6:0] SC_TAB        = 7'h0F;
    localparam logic [6:0] SC_ESCAPE     = 7'h01;
    localparam logic [6:0] SC_LSHIFT     = 7'h2A;
    localparam logic [6:0] SC_RSHIFT     = 7'h36;
    localparam logic [6:0] SC_CTRL       = 7'h1D;
    localparam logic [6:0] SC_CAPS       = 7'h3A;
    localparam logic [6:0] SC_UP         = 7'h48;
    localparam logic [6:0] SC_DOWN       = 7'h50;
    localparam logic [6:0] SC_RIGHT      = 7'h4D;
    localparam logic [6:0] SC_LEFT       = 7'h4B;

    localparam logic [6:0] ASC_LF      = 7'h0A;
    localparam logic [6:0] ASC_BS      = 7'h08;
    localparam logic [6:0] ASC_TAB     = 7'h09;
    localparam logic [6:0] ASC_ESC     = 7'h1B;
    localparam logic [6:0] ASC_LBRACK  = 7'h5B;
    localparam logic [6:0] ASC_AT      = 7'h40;
    localparam logic [6:0] ASC_USCORE  = 7'h5F;
    localparam logic [6:0] ASC_UC_A    = 7'h41;
    localparam logic [6:0] ASC_UC_B    = 7'h42;
    localparam logic [6:0] ASC_UC_C    = 7'h43;
    localparam logic [6:0] ASC_UC_D    = 7'h44;
    localparam logic [6:0] ASC_UC_Z    = 7'h5A;
    localparam logic [6:0] ASC_LC_A    = 7'h61;
    localparam logic [6:0] ASC_LC_Z    = 7'h7A;
    localparam logic [6:0] ASC_CASE    = 7'h20;
    localparam logic [6:0] CTRL_LOWER  = 7'h60;
    localparam logic [6:0] CTRL_OTHER  = 7'h40;
    localparam logic [6:0] LED_CAPS_ON = 7'h04;
    localparam logic [6:0] LED_OFF     = 7'h00;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_LED  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [6:0] value;
    } res_t;

    typedef struct packed {
        logic [1:0]     count;
        res_t [2:0]     slot;
    } burst_t;

    function automatic logic is_upper(input logic [6:0] c);
        return (c >= ASC_UC_A) && (c <= ASC_UC_Z);
    endfunction

    function automatic logic is_lower(input logic [6:0] c);
        return (c >= ASC_LC_A) && (c <= ASC_LC_Z);
    endfunction

    function automatic logic [7:0] key_plain(input logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'd2:  c = "1";  7'd3:  c = "2";  7'd4:  c = "3";  7'd5:  c = "4";
            7'd6:  c = "5";  7'd7:  c = "6";  7'd8:  c = "7";  7'd9:  c = "8";
            7'd10: c = "9";  7'd11: c = "0";  7'd12: c = "-";  7'd13: c = "=";
            7'd16: c = "q";  7'd17: c = "w";  7'd18: c = "e";  7'd19: c = "r";
            7'd20: c = "t";  7'd21: c = "y";  7'd22: c = "u";  7'd23: c = "i";
            7'd24: c = "o";  7'd25: c = "p";  7'd26: c = "[";  7'd27: c = "]";
            7'd30: c = "a";  7'd31: c = "s";  7'd32: c = "d";  7'd33: c = "f";
            7'd34: c = "g";  7'd35: c = "h";  7'd36: c = "j";  7'd37: c = "k";
            7'd38: c = "l";  7'd39: c = ";";  7'd40: c = 8'h27; 7'd41: c = 8'h60;
            7'd43: c = 8'h5C; 7'd44: c = "z"; 7'd45: c = "x";  7'd46: c = "c";
            7'd47: c = "v";  7'd48: c = "b";  7'd49: c = "n";  7'd50: c = "m";
            7'd51: c = ",";  7'd52: c = ".";  7'd53: c = "/";  7'd55: c = "*";
            7'd71: c = "7";  7'd72: c = "8";  7'd73: c = "9";  7'd74: c = "-";
            7'd75: c = "4";  7'd76: c = "5";  7'd77: c = "6";  7'd78: c = "+";
            7'd79: c = "1";  7'd80: c = "2";  7'd81: c = "3";  7'd82: c = "0";
            7'd83: c = ".";
            default: c = " ";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] key_shifted(input logic [6:0] code);
        logic [7:0] c;
        logic [7:0] p;
        p = key_plain(code);
        case (code)
            7'd2:  c = "!";  7'd3:  c = "@";  7'd4:  c = "#";  7'd5:  c = "$";
            7'd6:  c = "%";  7'd7:  c = "^";  7'd8:  c = "&";  7'd9:  c = "*";
            7'd10: c = "(";  7'd11: c = ")";  7'd12: c = "_";  7'd13: c = "+";
            7'd26: c = "{";  7'd27: c = "}";  7'd39: c = ":";  7'd40: c = 8'h22;
            7'd41: c = "~";  7'd43: c = "|";  7'd51: c = "<";  7'd52: c = ">";
            7'd53: c = "?";
            default: c = is_lower(p[6:0]) ? (p ^ {1'b0, ASC_CASE}) : p;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] key_lookup(input logic [6:0] code, input logic shifted,
                                              input logic caps);
        logic [7:0] c;
        logic [6:0] ch;
        c  = shifted ? key_shifted(code) : key_plain(code);
        ch = c[6:0];
        if (caps && (is_lower(ch) || is_upper(ch))) begin
            ch = ch ^ ASC_CASE;
        end
        return ch;
    endfunction

endpackage

// ----- rtl/ps2s1_decode.sv -----
module ps2s1_decode
    import ps2s1_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] byte_i,
    input  logic       fire,
    output burst_t     burst
);

    logic ext_reg,   ext_next;
    logic lsh_reg,   lsh_next;
    logic rsh_reg,   rsh_next;
    logic ctrl_reg,  ctrl_next;
    logic caps_reg,  caps_next;
    logic       rel;
    logic [6:0] code;
    logic [6:0] ch;
    logic [6:0] arrow;

    always_comb begin
        ext_next  = ext_reg;
        lsh_next  = lsh_reg;
        rsh_next  = rsh_reg;
        ctrl_next = ctrl_reg;
        caps_next = caps_reg;
        burst     = '0;
        ch        = '0;
        arrow     = '0;
        rel       = byte_i[7];
        code      = byte_i[6:0];
        if (byte_i == SC_EXT_PREFIX) begin
            ext_next = 1'b1;
        end else begin
            if (ext_reg) begin
                case (code)
                    SC_UP:    arrow = ASC_UC_A;
                    SC_DOWN:  arrow = ASC_UC_B;
                    SC_RIGHT: arrow = ASC_UC_C;
                    SC_LEFT:  arrow = ASC_UC_D;
                    default:  arrow = '0;
                endcase
            end else begin
                case (code)
                    SC_ENTER:     ch = ASC_LF;
                    SC_BACKSPACE: ch = ASC_BS;
                    SC_TAB:       ch = ASC_TAB;
                    SC_ESCAPE:    ch = ASC_ESC;
                    SC_LSHIFT:    lsh_next  = !rel;
                    SC_RSHIFT:    rsh_next  = !rel;
                    SC_CTRL:      ctrl_next = !rel;
                    SC_CAPS: begin
                        if (!rel) begin
                            caps_next = !caps_reg;
                            burst.count = 2'd1;
                            burst.slot[0].kind  = KIND_LED;
                            burst.slot[0].value = caps_next ? LED_CAPS_ON : LED_OFF;
                        end
                    end
                    default: begin
                        if ({1'b0, code} < 8'(KEY_TABLE_LENGTH)) begin
                            ch = key_lookup(code, lsh_reg ^ rsh_reg, caps_reg);
                        end
                    end
                endcase
            end
            ext_next = 1'b0;
            if (!rel && (ch != '0 || arrow != '0)) begin
                if (ctrl_reg) begin
                    if (is_lower(ch)) begin
                        burst.count = 2'd1;
                        burst.slot[0].kind  = KIND_CHAR;
                        burst.slot[0].value = ch - CTRL_LOWER;
                    end else if (ch >= ASC_AT && ch <= ASC_USCORE && !is_upper(ch)) begin
                        burst.count = 2'd1;
                        burst.slot[0].kind  = KIND_CHAR;
                        burst.slot[0].value = ch - CTRL_OTHER;
                    end
                end else if (arrow != '0) begin
                    burst.count = 2'd3;
                    burst.slot[0].kind  = KIND_CHAR;
                    burst.slot[0].value = ASC_ESC;
                    burst.slot[1].kind  = KIND_CHAR;
                    burst.slot[1].value = ASC_LBRACK;
                    burst.slot[2].kind  = KIND_CHAR;
                    burst.slot[2].value = arrow;
                end else begin
                    burst.count = 2'd1;
                    burst.slot[0].kind  = KIND_CHAR;
                    burst.slot[0].value = ch;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg  <= 1'b0;
            lsh_reg  <= 1'b0;
            rsh_reg  <= 1'b0;
            ctrl_reg <= 1'b0;
            caps_reg <= 1'b0;
        end else if (fire) begin
            ext_reg  <= ext_next;
            lsh_reg  <= lsh_next;
            rsh_reg  <= rsh_next;
            ctrl_reg <= ctrl_next;
            caps_reg <= caps_next;
        end
    end

endmodule

// ----- rtl/ps2s1_out_buf.sv -----
module ps2s1_out_buf
    import ps2s1_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  burst_t     burst,
    input  logic       load,
    output logic       load_ok,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [6:0] m_value,
    output logic       m_last
);

    res_t [2:0] slot_reg;
    logic [1:0] cnt_reg;

    assign m_valid = cnt_reg != 2'd0;
    assign m_last  = cnt_reg == 2'd1;
    assign m_kind  = slot_reg[0].kind;
    assign m_value = slot_reg[0].value;
    assign load_ok = (cnt_reg == 2'd0) || (m_last && m_ready);

    // results leave from slot 0, the rest shift down on each transfer
    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= burst.slot;
        end else if (m_valid && m_ready) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= burst.count;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ----- rtl/ps2_set1_scancode_to_ascii.sv -----
// path: the input register feeds the result buffer, so the first result of a byte is
// registered in both before it can leave, and waits while the result buffer is busy
// throughput: one byte per cycle while each byte yields at most one result and m_ready is high
// a byte yielding several results (arrow keys: 3) holds the single result port until all are taken
// reset: synchronous active-low aresetn clears modifier, caps and extended flags and
// empties both the input register and the result buffer
module ps2_set1_scancode_to_ascii
    import ps2s1_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [6:0] m_value,
    output logic       m_last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       load_ok;
    logic       fire;
    burst_t     burst;

    assign fire    = in_valid_reg && load_ok;
    assign s_ready = !in_valid_reg || load_ok;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_scan_byte;
        end
    end

    ps2s1_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_i  (in_byte_reg),
        .fire    (fire),
        .burst   (burst)
    );

    ps2s1_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .burst   (burst),
        .load    (fire),
        .load_ok (load_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_value (m_value),
        .m_last  (m_last)
    );

    // a multi-result burst never has a gap
    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("result burst broken");

    // the led byte is always the only result of its byte
    a_led_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_LED) |-> m_last)
        else $error("led byte not last");

    a_led_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_LED) |-> (m_value == LED_OFF || m_value == LED_CAPS_ON))
        else $error("bad led byte");

    // arrow sequence: escape is followed by a bracket
    a_arrow_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last && m_value == ASC_ESC) |=> (m_value == ASC_LBRACK))
        else $error("arrow sequence out of order");

endmodule
